/* rtl/masked_byte_signature_search_assert.svh */
// Assertion helpers used by the checker module.
`ifndef MASKED_BYTE_SIGNATURE_SEARCH_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while reset is active.
`define MBSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while reset is active.
`define MBSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mbss_pkg.sv */
package mbss_pkg;

  // Fixed field widths
  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int LEN_W      = 5;
  localparam int MASK_W     = 16;
  localparam int PAT_WORD_W = 64;
  localparam int SIG_BYTES  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_CARE_MASK      = 3'd2,
    CFG_PATTERN_LENGTH = 3'd3,
    CFG_BASE_ADDRESS   = 3'd4,
    CFG_MATCH_MODE     = 3'd5
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [MASK_W-1:0] CARE_MASK_RST = '1;
  localparam logic [LEN_W-1:0]  LENGTH_RST    = LEN_W'(1);

endpackage

/* rtl/masked_byte_signature_search.sv */
// Path: an accepted byte is registered in the input stage, then in the result registers that drive the result ports.
// Throughput: one byte per cycle unless out_stall_i holds the result stage; the window
// compare, the address add and the count update each sit between a pair of registers, so nothing iterates.
// Reset (rst_ni low, asynchronous): configuration returns to its defaults,
// the byte window, position, match count and first-match flag clear.
module masked_byte_signature_search
  import mbss_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_W-1:0]     data_byte_i,
  input  logic                  last_byte_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  match_found_o,
  output logic [ADDR_W-1:0]     match_address_o,
  output logic [COUNT_W-1:0]    match_count_o,
  output logic                  scan_done_o,
  output logic                  not_found_o,
  // configuration port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN);

  // Configuration registers
  logic [PAT_WORD_W-1:0] pattern_low_q, pattern_high_q;
  logic [MASK_W-1:0]     care_mask_q;
  logic [LEN_W-1:0]      pattern_length_q;
  logic [ADDR_W-1:0]     base_address_q;
  logic                  match_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      care_mask_q      <= CARE_MASK_RST;
      pattern_length_q <= LENGTH_RST;
      base_address_q   <= '0;
      match_mode_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data_i;
        CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data_i;
        CFG_CARE_MASK:      care_mask_q      <= cfg_data_i[MASK_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[LEN_W-1:0];
        CFG_BASE_ADDRESS:   base_address_q   <= cfg_data_i[ADDR_W-1:0];
        CFG_MATCH_MODE:     match_mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic s1_valid_q, out_valid_q;
  logic out_ready, s1_adv, s1_ready, in_acc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign s1_ready   = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (out_ready) out_valid_q <= s1_valid_q;
    end
  end

  // Input stage: byte window and position; a scan starts fresh after a last byte
  logic [DATA_W-1:0] window_q [MAX_PATTERN];
  logic [DATA_W-1:0] window_d [MAX_PATTERN];
  logic [ADDR_W-1:0] pos_q, pos_d, pos_base;
  logic              s1_last_q;

  always_comb begin
    window_d[0] = data_byte_i;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_d[j] = s1_last_q ? '0 : window_q[j-1];
    end
    pos_base = s1_last_q ? '0 : pos_q;
    pos_d    = (pos_base == '1) ? pos_base : pos_base + ADDR_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_PATTERN; j++) window_q[j] <= '0;
      pos_q     <= '0;
      s1_last_q <= 1'b0;
    end else if (in_acc) begin
      window_q  <= window_d;
      pos_q     <= pos_d;
      s1_last_q <= last_byte_i;
    end
  end

  // Effective length: zero acts as one, oversize clips to the window depth
  logic [LEN_W-1:0] len_use;

  always_comb begin
    if (pattern_length_q == '0) begin
      len_use = LEN_W'(1);
    end else if (pattern_length_q > MaxLen) begin
      len_use = MaxLen;
    end else begin
      len_use = pattern_length_q;
    end
  end

  // Align window bytes to signature bytes: byte i sits len-1-i back from newest
  logic [DATA_W-1:0]            sel_byte [MAX_PATTERN];
  logic [SIG_BYTES*DATA_W-1:0]  sig_all;

  assign sig_all = {pattern_high_q, pattern_low_q};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sel_byte[i] = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (LEN_W'(j) == len_use - LEN_W'(1) - LEN_W'(i)) sel_byte[i] = window_q[j];
      end
    end
  end

  // Masked compare over the first len_use window bytes
  logic hit;

  always_comb begin
    hit = (ADDR_W'(len_use) <= pos_q);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < len_use) && care_mask_q[i] &&
          (sel_byte[i] != sig_all[i*DATA_W +: DATA_W])) begin
        hit = 1'b0;
      end
    end
  end

  // Result stage: report decision, saturating count, start address
  logic                 match_found_q, match_found_d;
  logic [ADDR_W-1:0]    match_address_q, match_address_d;
  logic [COUNT_W-1:0]   match_count_q, match_count_d, count_base;
  logic                 scan_done_q;
  logic                 not_found_q, not_found_d;
  logic                 first_found_q, first_found_d, first_base;
  logic [ADDR_W-1:0]    start_addr;

  assign start_addr = base_address_q + (pos_q - ADDR_W'(len_use));

  always_comb begin
    count_base      = scan_done_q ? '0 : match_count_q;
    first_base      = scan_done_q ? 1'b0 : first_found_q;
    match_found_d   = hit && (match_mode_q || !first_base);
    first_found_d   = first_base || (hit && !match_mode_q);
    match_address_d = match_found_d ? start_addr : '0;
    match_count_d   = (match_found_d && (count_base != '1)) ?
                      count_base + COUNT_W'(1) : count_base;
    not_found_d     = s1_last_q && (match_count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q   <= 1'b0;
      match_address_q <= '0;
      match_count_q   <= '0;
      scan_done_q     <= 1'b0;
      not_found_q     <= 1'b0;
      first_found_q   <= 1'b0;
    end else if (s1_adv) begin
      match_found_q   <= match_found_d;
      match_address_q <= match_address_d;
      match_count_q   <= match_count_d;
      scan_done_q     <= s1_last_q;
      not_found_q     <= not_found_d;
      first_found_q   <= first_found_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_found_o   = match_found_q;
  assign match_address_o = match_address_q;
  assign match_count_o   = match_count_q;
  assign scan_done_o     = scan_done_q;
  assign not_found_o     = not_found_q;

endmodule

/* rtl/mbss_checker.sv */
`include "masked_byte_signature_search_assert.svh"

module mbss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        match_found_o,
  input logic [31:0] match_address_o,
  input logic [31:0] match_count_o,
  input logic        scan_done_o,
  input logic        not_found_o
);

  // Whole result payload, for the hold check
  logic [66:0] res_bits;
  logic        res_nf_ok;

  assign res_bits  = {match_found_o, match_address_o, match_count_o, scan_done_o, not_found_o};
  assign res_nf_ok = scan_done_o && !match_found_o && (match_count_o == 32'd0);

  // A stalled result request keeps its payload
  `MBSS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(res_bits), "result changed while stalled")

  // Not-found only closes a scan with nothing reported
  `MBSS_ASSERT_NOW(a_not_found, out_valid_o && not_found_o, res_nf_ok, "not_found with a match")

  // A reported match is always counted
  `MBSS_ASSERT_NOW(a_found_count, out_valid_o && match_found_o, match_count_o != 32'd0, "zero count")

  // Address is zero when nothing is reported
  `MBSS_ASSERT_NOW(a_addr_zero, out_valid_o && !match_found_o, match_address_o == 32'd0, "stray address")

endmodule

bind masked_byte_signature_search mbss_checker u_mbss_checker (.*);
